// ----- src/buf_uart_pkg.sv -----
// Shared types and constants for the buffered UART front end.
// No dependencies; imported by the ring, the top level and the checker.
package buf_uart_pkg;

  // default ring depths, in bytes
  localparam int unsigned RX_DEPTH_DEF = 8;
  localparam int unsigned TX_DEPTH_DEF = 8;

  // reported counts are masked to this many bits
  localparam int unsigned COUNT_OUT_W = 4;
  // wide enough for a count at the largest supported depth
  localparam int unsigned CNT_EXT_W = 9;

  // register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0] REG_NEWLINE_EXPAND = 1'b0;

  // characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // request codes
  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_RX   = 2'd2,
    OP_DONE = 2'd3
  } op_t;

  // write/read request to one ring
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       pend_en;
    logic [7:0] pend_data;
    logic       rd_en;
  } ring_req_t;

  // ring status seen by the control logic
  typedef struct packed {
    logic empty;
    logic full;
    logic room2;
    logic pend_busy;
  } ring_stat_t;

endpackage

// ----- src/buf_uart_ring.sv -----
// Byte ring with one write port and a registered read port.
// Depends on buf_uart_pkg for the request and status structs.
module buf_uart_ring import buf_uart_pkg::*; #(
  parameter int unsigned DEPTH = TX_DEPTH_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_req_t     req,
  output logic [7:0]    rd_data,
  output logic [CW-1:0] count,
  output ring_stat_t    stat
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [DEPTH];
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] wr_idx_next;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] rd_idx_next;
  logic [CW-1:0] count_next;
  logic          pend_valid;
  logic [7:0]    pend_data;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] res;
    if (idx == IW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IW'(1);
    end
    return res;
  endfunction

  // pointer and count update
  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    count_next  = count;
    if (req.wr_en || pend_valid) begin
      wr_idx_next = idx_inc(wr_idx);
    end
    if (req.rd_en) begin
      rd_idx_next = idx_inc(rd_idx);
    end
    if (req.wr_en) begin
      count_next = count_next + (req.pend_en ? CW'(2) : CW'(1));
    end
    if (req.rd_en) begin
      count_next = count_next - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      rd_idx     <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      wr_idx     <= wr_idx_next;
      rd_idx     <= rd_idx_next;
      count      <= count_next;
      pend_valid <= req.wr_en && req.pend_en;
    end
  end

  // second byte of a pair, written in the following cycle
  always_ff @(posedge clk) begin
    if (req.wr_en && req.pend_en) begin
      pend_data <= req.pend_data;
    end
  end

  // storage: one write, one registered read
  always_ff @(posedge clk) begin
    if (pend_valid) begin
      mem[wr_idx] <= pend_data;
    end else if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // status
  always_comb begin
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(DEPTH));
    stat.room2     = (count < CW'(DEPTH - 1));
    stat.pend_busy = pend_valid;
  end

endmodule

// ----- src/buffered_uart_fifo_front.sv -----
// Buffered UART front end: a receive ring, a transmit ring and a result register.
// Depends on buf_uart_pkg and buf_uart_ring.
//
// Usage: each request on the input channel (op, data) is one of host put,
// host get, byte received from the line, or transmit done. Every request gives
// exactly one result on the output channel, in the cycle after it is accepted.
// A put goes straight to an idle transmitter (tx_valid) or is queued; a put
// with no room is refused (put_accepted low). With newline_expand set, a line
// feed is sent as carriage return then line feed, both or neither. A host get
// returns the oldest received byte; a line byte arriving at a full receive
// ring is dropped and flagged with rx_overflow. Counts and flags in a result
// show the state after that request.
// Throughput: one request per cycle while the receiver takes each result and
// the transmit ring is not storing a pair. An expanded newline queued behind
// a busy transmitter holds off the next request, since the transmit ring's
// single write port stores carriage return and line feed one after the other.
// When the receiver stalls, the result holds and in_ready drops; the next
// request is taken in the cycle the result is taken.
// Reset: both rings empty, transmitter idle, newline_expand set to 1; ready
// in the first cycle after reset is released, with no clearing pass.
// newline_expand is written through the APB port at byte address 0.
module buffered_uart_fifo_front import buf_uart_pkg::*; #(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  logic [7:0]             data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   tx_valid,
  output logic [7:0]             tx_byte,
  output logic                   read_valid,
  output logic [7:0]             read_byte,
  output logic                   put_accepted,
  output logic                   rx_overflow,
  output logic [COUNT_OUT_W-1:0] rx_count,
  output logic [COUNT_OUT_W-1:0] tx_count,
  output logic                   tx_busy,
  output logic                   tx_full,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);

  logic             newline_expand;
  logic             tx_in_flight;
  logic             tx_in_flight_next;
  logic             in_fire;
  logic             pair;
  logic             put_ok;

  ring_req_t        rx_req;
  ring_req_t        tx_req;
  ring_stat_t       rx_stat;
  ring_stat_t       tx_stat;
  logic [7:0]       rx_rd_data;
  logic [7:0]       tx_rd_data;
  logic [RX_CW-1:0] rx_cnt;
  logic [TX_CW-1:0] tx_cnt;
  logic [CNT_EXT_W-1:0] rx_cnt_ext;
  logic [CNT_EXT_W-1:0] tx_cnt_ext;

  // result fields decided this cycle
  logic             tx_send_next;
  logic             tx_from_ring_next;
  logic [7:0]       tx_direct_next;
  logic             read_hit_next;
  logic             put_acc_next;
  logic             rx_ovf_next;

  // result register
  logic             res_valid;
  logic             res_tx_send;
  logic             res_tx_from_ring;
  logic [7:0]       res_tx_direct;
  logic             res_read_hit;
  logic             res_put_acc;
  logic             res_rx_ovf;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_NEWLINE_EXPAND)
                ? {{(APB_DATA_W - 1){1'b0}}, newline_expand} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_expand <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && paddr[APB_ADDR_W-1:2] == REG_NEWLINE_EXPAND) begin
      newline_expand <= pwdata[0];
    end
  end

  // handshake: hold off while a result waits or the tx ring finishes a pair
  assign in_ready = (!res_valid || out_ready) && !tx_stat.pend_busy;
  assign in_fire  = in_valid && in_ready;

  // put admission
  assign pair = newline_expand && (data == CH_LF);
  always_comb begin
    if (pair) begin
      put_ok = tx_in_flight ? tx_stat.room2 : !tx_stat.full;
    end else begin
      put_ok = tx_in_flight ? !tx_stat.full : 1'b1;
    end
  end

  // request decode
  always_comb begin
    rx_req            = '0;
    tx_req            = '0;
    tx_in_flight_next = tx_in_flight;
    tx_send_next      = 1'b0;
    tx_from_ring_next = 1'b0;
    tx_direct_next    = '0;
    read_hit_next     = 1'b0;
    put_acc_next      = 1'b0;
    rx_ovf_next       = 1'b0;
    case (op_t'(op))
      OP_PUT: begin
        if (put_ok) begin
          put_acc_next      = 1'b1;
          tx_in_flight_next = 1'b1;
          if (pair && tx_in_flight) begin
            tx_req.wr_en     = 1'b1;
            tx_req.wr_data   = CH_CR;
            tx_req.pend_en   = 1'b1;
            tx_req.pend_data = data;
          end else if (pair) begin
            tx_send_next   = 1'b1;
            tx_direct_next = CH_CR;
            tx_req.wr_en   = 1'b1;
            tx_req.wr_data = data;
          end else if (tx_in_flight) begin
            tx_req.wr_en   = 1'b1;
            tx_req.wr_data = data;
          end else begin
            tx_send_next   = 1'b1;
            tx_direct_next = data;
          end
        end
      end
      OP_GET: begin
        if (!rx_stat.empty) begin
          read_hit_next = 1'b1;
          rx_req.rd_en  = 1'b1;
        end
      end
      OP_RX: begin
        if (!rx_stat.full) begin
          rx_req.wr_en   = 1'b1;
          rx_req.wr_data = data;
        end else begin
          rx_ovf_next = 1'b1;
        end
      end
      OP_DONE: begin
        if (!tx_stat.empty) begin
          tx_send_next      = 1'b1;
          tx_from_ring_next = 1'b1;
          tx_req.rd_en      = 1'b1;
          tx_in_flight_next = 1'b1;
        end else begin
          tx_in_flight_next = 1'b0;
        end
      end
      default: begin
        tx_in_flight_next = tx_in_flight;
      end
    endcase
    // nothing moves unless the request is taken
    if (!in_fire) begin
      rx_req            = '0;
      tx_req            = '0;
      tx_in_flight_next = tx_in_flight;
    end
  end

  // rings
  buf_uart_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (rx_req),
    .rd_data (rx_rd_data),
    .count   (rx_cnt),
    .stat    (rx_stat)
  );

  buf_uart_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (tx_req),
    .rd_data (tx_rd_data),
    .count   (tx_cnt),
    .stat    (tx_stat)
  );

  // transmitter state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_in_flight <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      tx_in_flight <= tx_in_flight_next;
      if (in_fire) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_tx_send      <= tx_send_next;
      res_tx_from_ring <= tx_from_ring_next;
      res_tx_direct    <= tx_direct_next;
      res_read_hit     <= read_hit_next;
      res_put_acc      <= put_acc_next;
      res_rx_ovf       <= rx_ovf_next;
    end
  end

  // outputs; counts and flags are live, they only change with the next request
  assign rx_cnt_ext   = CNT_EXT_W'(rx_cnt);
  assign tx_cnt_ext   = CNT_EXT_W'(tx_cnt);
  assign out_valid    = res_valid;
  assign tx_valid     = res_tx_send;
  assign tx_byte      = !res_tx_send ? 8'h00
                      : (res_tx_from_ring ? tx_rd_data : res_tx_direct);
  assign read_valid   = res_read_hit;
  assign read_byte    = res_read_hit ? rx_rd_data : 8'h00;
  assign put_accepted = res_put_acc;
  assign rx_overflow  = res_rx_ovf;
  assign rx_count     = rx_cnt_ext[COUNT_OUT_W-1:0];
  assign tx_count     = tx_cnt_ext[COUNT_OUT_W-1:0];
  assign tx_busy      = tx_in_flight;
  assign tx_full      = tx_stat.full;

endmodule

// ----- src/buf_uart_checker.sv -----
// Port-level checks for the buffered UART front end, bound to the top level.
// Depends on buf_uart_pkg; attaches to buffered_uart_fifo_front.
module buf_uart_checker import buf_uart_pkg::*; #(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   tx_valid,
  input logic [7:0]             tx_byte,
  input logic                   put_accepted,
  input logic [COUNT_OUT_W-1:0] tx_count,
  input logic                   tx_busy,
  input logic                   tx_full
);

  // no result is shown in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result keeps its transmit byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte))
    else $error("stalled result changed");

  // nothing handed to the transmitter means a zero byte
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("tx_byte nonzero without tx_valid");

  // a put that was queued leaves the transmitter busy
  a_queued_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && put_accepted && !tx_valid |-> tx_busy)
    else $error("queued put with idle transmitter");

  // full flag agrees with the count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_full |-> tx_count == COUNT_OUT_W'(TX_DEPTH % 16))
    else $error("tx_full disagrees with tx_count");

endmodule

bind buffered_uart_fifo_front buf_uart_checker #(.TX_DEPTH(TX_DEPTH)) u_buf_uart_checker (.*);
